### rtl/core/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define RCBP_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rcbp assertion failed");

// antecedent in one cycle implies consequent in the next
`define RCBP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcbp assertion failed");

`endif

### rtl/core/rcbp_pkg.sv
package rcbp_pkg;

   localparam int MAX_FRAME_DEFAULT = 64;

   localparam logic [7:0] SPEED_STEP_RESET = 8'd10;
   localparam logic [7:0] SPEED_MAX_RESET  = 8'd60;

   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPEED_STEP = 1'b0,
      CSR_SPEED_MAX  = 1'b1
   } csr_index_type;

   // command bytes
   localparam logic [7:0] BYTE_DIR_LO     = 8'h41;
   localparam logic [7:0] BYTE_DIR_HI     = 8'h48;
   localparam logic [7:0] BYTE_DIGIT_LIM  = 8'd10;
   localparam logic [7:0] BYTE_STOP       = 8'h5A;
   localparam logic [7:0] BYTE_SPEED_DOWN = 8'h59;
   localparam logic [7:0] BYTE_SPEED_UP   = 8'h58;
   localparam logic [7:0] BYTE_OPEN       = 8'h7B;
   localparam logic [7:0] BYTE_CLOSE      = 8'h7D;
   localparam logic [7:0] BYTE_REPORT     = 8'h50;
   localparam logic [7:0] BYTE_SAVE       = 8'h57;
   localparam logic [7:0] BYTE_ID_NONE    = 8'h23;
   localparam logic [7:0] BYTE_ID_KP      = 8'h31;
   localparam logic [7:0] BYTE_ID_KI      = 8'h32;
   localparam logic [7:0] BYTE_ZERO_CHAR  = 8'h30;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } byte_slot_type;

   typedef struct packed {
      logic [3:0]  direction;
      logic [7:0]  speed;
      logic [31:0] kp_gain;
      logic [31:0] ki_gain;
      logic        kp_written;
      logic        ki_written;
      logic        report_request;
      logic        save_request;
      logic [7:0]  echo_byte;
   } rsp_type;

endpackage

### rtl/core/rcbp_in_stage.sv
module rcbp_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [7:0]             req_rx_byte,
   output logic                   req_stall,
   input  logic                   advance,
   output rcbp_pkg::byte_slot_type slot
);
   import rcbp_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       take;

   // slot frees when its byte moves on in the same cycle
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take || (valid_ff && !advance);
   assign byte_in   = take ? req_rx_byte : byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign slot.valid = valid_ff;
   assign slot.data  = byte_ff;

endmodule

### rtl/core/rcbp_horner.sv
module rcbp_horner (
   input  logic signed [31:0] acc,
   input  logic        [7:0]  digit_byte,
   output logic signed [31:0] acc_next
);
   import rcbp_pkg::*;

   localparam logic signed [35:0] SAT_MAX = 36'sh0_7FFF_FFFF;
   localparam logic signed [35:0] SAT_MIN = -36'sh0_8000_0000;

   logic signed [35:0] acc_wide;
   logic signed [35:0] times_ten;
   logic signed [35:0] digit_val;
   logic signed [35:0] sum;

   // times ten as two shifts, then add the digit value (byte minus the character offset)
   assign acc_wide  = 36'(acc);
   assign times_ten = (acc_wide <<< 3) + (acc_wide <<< 1);
   assign digit_val = $signed({28'd0, digit_byte}) - $signed({28'd0, BYTE_ZERO_CHAR});
   assign sum       = times_ten + digit_val;

   always_comb begin
      priority if (sum > SAT_MAX) begin
         acc_next = 32'sh7FFF_FFFF;
      end else if (sum < SAT_MIN) begin
         acc_next = 32'sh8000_0000;
      end else begin
         acc_next = sum[31:0];
      end
   end

endmodule

### rtl/core/rcbp_core.sv
`include "assert_macros.svh"

module rcbp_core #(
   parameter int MAX_FRAME = rcbp_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rcbp_pkg::byte_slot_type             slot,
   output logic                                advance,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output rcbp_pkg::rsp_type                   rsp,
   input  logic                                csr_write_enable,
   input  logic [rcbp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [7:0]                          csr_write_data
);
   import rcbp_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);

   logic [7:0] speed_step_ff, speed_max_ff;

   logic [3:0]        direction_ff, direction_in;
   logic [7:0]        speed_ff, speed_in;
   logic              in_frame_ff, in_frame_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        id_ff, id_in;
   logic [7:0]        fourth_ff, fourth_in;
   logic signed [31:0] acc_ff, acc_in, acc_step;
   logic [31:0]       kp_ff, kp_in, ki_ff, ki_in;
   logic              kpw_in, kiw_in, rep_in, sav_in;
   logic              kpw_ff, kiw_ff, rep_ff, sav_ff;
   logic [7:0]        echo_ff;
   logic              rsp_valid_ff;

   logic [7:0] b;
   logic [8:0] speed_pre;
   logic       open_now;

   assign b       = slot.data;
   assign advance = slot.valid && (!rsp_valid_ff || !rsp_stall);

   rcbp_horner u_horner (
      .acc        (acc_ff),
      .digit_byte (b),
      .acc_next   (acc_step)
   );

   always_comb begin
      direction_in = direction_ff;
      speed_pre    = {1'b0, speed_ff};
      priority if (b >= BYTE_DIR_LO && b <= BYTE_DIR_HI) begin
         direction_in = b[3:0];
      end else if (b < BYTE_DIGIT_LIM) begin
         direction_in = b[3:0];
      end else if (b == BYTE_STOP) begin
         direction_in = 4'd0;
      end else if (b == BYTE_SPEED_DOWN) begin
         speed_pre = (speed_ff < speed_step_ff) ? 9'd0
                   : {1'b0, speed_ff} - {1'b0, speed_step_ff};
      end else if (b == BYTE_SPEED_UP) begin
         speed_pre = {1'b0, speed_ff} + {1'b0, speed_step_ff};
      end else begin
         speed_pre = {1'b0, speed_ff};
      end
      speed_in = (speed_pre > {1'b0, speed_max_ff}) ? speed_max_ff : speed_pre[7:0];
   end

   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      id_in       = id_ff;
      fourth_in   = fourth_ff;
      acc_in      = acc_ff;
      kp_in       = kp_ff;
      ki_in       = ki_ff;
      kpw_in      = 1'b0;
      kiw_in      = 1'b0;
      rep_in      = 1'b0;
      sav_in      = 1'b0;
      open_now    = in_frame_ff || (b == BYTE_OPEN);
      if (b == BYTE_CLOSE) begin
         priority if (fourth_ff == BYTE_REPORT) begin
            rep_in = 1'b1;
         end else if (fourth_ff == BYTE_SAVE) begin
            sav_in = 1'b1;
         end else if (id_ff == BYTE_ID_KP) begin
            kp_in  = acc_ff;
            kpw_in = 1'b1;
         end else if (id_ff == BYTE_ID_KI) begin
            ki_in  = acc_ff;
            kiw_in = 1'b1;
         end else begin
            rep_in = 1'b0;
         end
         in_frame_in = 1'b0;
         count_in    = '0;
         id_in       = 8'd0;
         fourth_in   = 8'd0;
         acc_in      = 32'sd0;
      end else begin
         in_frame_in = open_now;
         if (open_now && count_ff < CNT_MAX) begin
            if (count_ff == CNT_W'(1)) begin
               id_in = b;
            end
            if (count_ff == CNT_W'(3)) begin
               fourth_in = b;
            end
            if (count_ff >= CNT_W'(3)) begin
               acc_in = acc_step;
            end
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_step_ff <= SPEED_STEP_RESET;
         speed_max_ff  <= SPEED_MAX_RESET;
         direction_ff  <= 4'd0;
         speed_ff      <= 8'd0;
         in_frame_ff   <= 1'b0;
         count_ff      <= '0;
         id_ff         <= 8'd0;
         fourth_ff     <= 8'd0;
         acc_ff        <= 32'sd0;
         kp_ff         <= 32'd0;
         ki_ff         <= 32'd0;
         rsp_valid_ff  <= 1'b0;
         kpw_ff        <= 1'b0;
         kiw_ff        <= 1'b0;
         rep_ff        <= 1'b0;
         sav_ff        <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_SPEED_STEP: speed_step_ff <= csr_write_data;
               CSR_SPEED_MAX:  speed_max_ff  <= csr_write_data;
               default: begin
               end
            endcase
         end
         if (advance) begin
            direction_ff <= direction_in;
            speed_ff     <= speed_in;
            in_frame_ff  <= in_frame_in;
            count_ff     <= count_in;
            id_ff        <= id_in;
            fourth_ff    <= fourth_in;
            acc_ff       <= acc_in;
            kp_ff        <= kp_in;
            ki_ff        <= ki_in;
            kpw_ff       <= kpw_in;
            kiw_ff       <= kiw_in;
            rep_ff       <= rep_in;
            sav_ff       <= sav_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         echo_ff <= b;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp.direction      = direction_ff;
   assign rsp.speed          = speed_ff;
   assign rsp.kp_gain        = kp_ff;
   assign rsp.ki_gain        = ki_ff;
   assign rsp.kp_written     = kpw_ff;
   assign rsp.ki_written     = kiw_ff;
   assign rsp.report_request = rep_ff;
   assign rsp.save_request   = sav_ff;
   assign rsp.echo_byte      = echo_ff;

   `RCBP_ASSERT(a_one_close_action, clock, reset, $onehot0({kpw_ff, kiw_ff, rep_ff, sav_ff}))
   `RCBP_ASSERT(a_count_bounded, clock, reset, count_ff <= CNT_MAX)
   `RCBP_ASSERT_NEXT(a_close_clears_frame, clock, reset, advance && b == BYTE_CLOSE, !in_frame_ff && count_ff == '0 && acc_ff == 32'sd0)
   `RCBP_ASSERT_NEXT(a_flags_only_on_close, clock, reset, advance && b != BYTE_CLOSE, !kpw_ff && !kiw_ff && !rep_ff && !sav_ff)

endmodule

### rtl/core/remote_command_byte_parser.sv
// Remote command byte parser: takes one received serial byte per transfer on the req_ channel
// and returns one result per byte on the rsp_ channel, in order. Bytes 'A'..'H' and 0..9 set
// the direction, 'Z' stops, 'Y'/'X' step the speed down/up by speed_step, clamped to
// 0..speed_max. Frames '{' id x req/digits '}' raise a report ('P') or save ('W') request or
// load kp (id '1') or ki (id '2') with a saturating signed 32-bit decimal value; frame bytes
// past MAX_FRAME are dropped. A byte can be accepted on every cycle while results are not
// held by rsp_stall; each byte passes the input register, then the result register that also
// holds the parser state, from which its result is presented. The state update between those
// registers is combinational, and the input register takes a new byte as its old one moves on.
// No start-up sweep: the block takes bytes straight after reset. Configuration via csr_ is
// to be written by the user only while the block is idle; the block does not enforce this.
module remote_command_byte_parser #(
   parameter int MAX_FRAME = rcbp_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // byte input channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_rx_byte,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [3:0]                     rsp_direction,
   output logic [7:0]                     rsp_speed,
   output logic signed [31:0]             rsp_kp_gain,
   output logic signed [31:0]             rsp_ki_gain,
   output logic                           rsp_kp_written,
   output logic                           rsp_ki_written,
   output logic                           rsp_report_request,
   output logic                           rsp_save_request,
   output logic [7:0]                     rsp_echo_byte,
   // configuration write port
   input  logic                           csr_write_enable,
   input  logic [rcbp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_write_data
);
   import rcbp_pkg::*;

   byte_slot_type slot;
   rsp_type       rsp;
   logic          advance;

   // input register, frees itself whenever its byte moves into the core
   rcbp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .advance     (advance),
      .slot        (slot)
   );

   // parser state, decimal accumulator and result register
   rcbp_core #(
      .MAX_FRAME (MAX_FRAME)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .slot             (slot),
      .advance          (advance),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // result fields straight from the result register
   assign rsp_direction      = rsp.direction;
   assign rsp_speed          = rsp.speed;
   assign rsp_kp_gain        = $signed(rsp.kp_gain);
   assign rsp_ki_gain        = $signed(rsp.ki_gain);
   assign rsp_kp_written     = rsp.kp_written;
   assign rsp_ki_written     = rsp.ki_written;
   assign rsp_report_request = rsp.report_request;
   assign rsp_save_request   = rsp.save_request;
   assign rsp_echo_byte      = rsp.echo_byte;

endmodule

### bench/rcbp_result_checker.sv
module rcbp_result_checker #(
   parameter int MAX_FRAME = rcbp_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [7:0]                     req_rx_byte,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [3:0]                     rsp_direction,
   input  logic [7:0]                     rsp_speed,
   input  logic signed [31:0]             rsp_kp_gain,
   input  logic signed [31:0]             rsp_ki_gain,
   input  logic                           rsp_kp_written,
   input  logic                           rsp_ki_written,
   input  logic                           rsp_report_request,
   input  logic                           rsp_save_request,
   input  logic [7:0]                     rsp_echo_byte,
   input  logic                           csr_write_enable,
   input  logic [rcbp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_write_data,
   input  logic                           test_done,
   output int                             fail_count,
   output int                             pending_count,
   output int                             checked_count,
   output int                             gain_loads,
   output int                             request_count
);
   import rcbp_pkg::*;

   // shadow copy of the parser state and its registers
   logic [7:0]         step_q;
   logic [7:0]         max_q;
   logic [3:0]         dir_q;
   logic [7:0]         speed_q;
   logic               in_frame_q;
   logic [6:0]         count_q;
   logic [7:0]         id_q;
   logic [7:0]         fourth_q;
   logic signed [31:0] acc_q;
   logic signed [31:0] kp_q;
   logic signed [31:0] ki_q;

   rsp_type pending_results[$];
   rsp_type want;
   rsp_type fresh;
   logic    leftovers_checked;

   initial begin
      fail_count        = 0;
      pending_count     = 0;
      checked_count     = 0;
      gain_loads        = 0;
      request_count     = 0;
      leftovers_checked = 1'b0;
   end

   task automatic note_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] exp_val);
      if (got !== exp_val)
         note_mismatch($sformatf("%s got %h want %h", name, got, exp_val));
   endtask

   // decimal accumulate with saturation at the signed 32-bit range
   function automatic logic signed [31:0] horner_next(input logic signed [31:0] acc,
                                                      input logic [7:0] b);
      longint v;
      v = longint'(acc) * 10 + longint'(b) - 48;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   task automatic clear_frame();
      in_frame_q = 1'b0;
      count_q    = '0;
      id_q       = '0;
      fourth_q   = '0;
      acc_q      = '0;
   endtask

   task automatic decode_byte(input logic [7:0] b, output rsp_type r);
      int sp;
      int step;
      int top;
      sp   = int'(speed_q);
      step = int'(step_q);
      top  = int'(max_q);
      r    = '0;
      if (b >= BYTE_DIR_LO && b <= BYTE_DIR_HI) dir_q = 4'(b - BYTE_DIR_LO + 8'd1);
      else if (b < BYTE_DIGIT_LIM) dir_q = b[3:0];
      else if (b == BYTE_STOP) dir_q = '0;
      else if (b == BYTE_SPEED_DOWN) sp = sp - step;
      else if (b == BYTE_SPEED_UP) sp = sp + step;
      if (sp < 0) sp = 0;
      if (sp > top) sp = top;
      speed_q = sp[7:0];

      if (b == BYTE_CLOSE) begin
         if (fourth_q == BYTE_REPORT) r.report_request = 1'b1;
         else if (fourth_q == BYTE_SAVE) r.save_request = 1'b1;
         else if (id_q == BYTE_ID_KP) begin
            kp_q = acc_q;
            r.kp_written = 1'b1;
         end else if (id_q == BYTE_ID_KI) begin
            ki_q = acc_q;
            r.ki_written = 1'b1;
         end
         clear_frame();
      end else begin
         if (b == BYTE_OPEN) in_frame_q = 1'b1;
         if (in_frame_q && count_q < MAX_FRAME) begin
            if (count_q == 7'd1) id_q = b;
            if (count_q == 7'd3) fourth_q = b;
            if (count_q >= 7'd3) acc_q = horner_next(acc_q, b);
            count_q = count_q + 7'd1;
         end
      end

      r.direction = dir_q;
      r.speed     = speed_q;
      r.kp_gain   = kp_q;
      r.ki_gain   = ki_q;
      r.echo_byte = b;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         step_q  = SPEED_STEP_RESET;
         max_q   = SPEED_MAX_RESET;
         dir_q   = '0;
         speed_q = '0;
         kp_q    = '0;
         ki_q    = '0;
         clear_frame();
         pending_results.delete();
         pending_count = 0;
      end else begin
         // a result cannot leave before its byte has passed the input and result registers, so pop before push
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               note_mismatch("result with nothing expected");
            end else begin
               want = pending_results.pop_front();
               checked_count++;
               check_field("direction", 32'(rsp_direction), 32'(want.direction));
               check_field("speed", 32'(rsp_speed), 32'(want.speed));
               check_field("kp_gain", rsp_kp_gain, want.kp_gain);
               check_field("ki_gain", rsp_ki_gain, want.ki_gain);
               check_field("kp_written", 32'(rsp_kp_written), 32'(want.kp_written));
               check_field("ki_written", 32'(rsp_ki_written), 32'(want.ki_written));
               check_field("report_request", 32'(rsp_report_request),
                           32'(want.report_request));
               check_field("save_request", 32'(rsp_save_request), 32'(want.save_request));
               check_field("echo_byte", 32'(rsp_echo_byte), 32'(want.echo_byte));
               if (want.kp_written || want.ki_written) gain_loads++;
               if (want.report_request || want.save_request) request_count++;
            end
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_rx_byte, fresh);
            pending_results.push_back(fresh);
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_SPEED_STEP) step_q = csr_write_data;
            else if (csr_index == CSR_SPEED_MAX) max_q = csr_write_data;
         end
         pending_count = pending_results.size();
         if (test_done && !leftovers_checked) begin
            leftovers_checked = 1'b1;
            if (pending_results.size() != 0)
               note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
         end
      end
   end

endmodule

### bench/tb_remote_command_byte_parser.sv
module tb_remote_command_byte_parser;
   import rcbp_pkg::*;

   localparam int NUM_SETTINGS      = 6;
   localparam int BYTES_PER_SETTING = 80;

   // every input starts at a known value, reset held from time zero
   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic [7:0]         req_rx_byte      = 8'h00;
   logic               rsp_stall        = 1'b0;
   logic               csr_write_enable = 1'b0;
   csr_index_type      csr_index        = CSR_SPEED_STEP;
   logic [7:0]         csr_write_data   = 8'h00;
   logic               test_done        = 1'b0;

   logic               req_stall;
   logic               rsp_valid;
   logic [3:0]         rsp_direction;
   logic [7:0]         rsp_speed;
   logic signed [31:0] rsp_kp_gain;
   logic signed [31:0] rsp_ki_gain;
   logic               rsp_kp_written;
   logic               rsp_ki_written;
   logic               rsp_report_request;
   logic               rsp_save_request;
   logic [7:0]         rsp_echo_byte;

   int fail_count;
   int pending_count;
   int checked_count;
   int gain_loads;
   int request_count;

   // percentage of cycles each side sits idle in the current phase
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int bytes_sent  = 0;

   logic [7:0] step_setting [NUM_SETTINGS];
   logic [7:0] max_setting  [NUM_SETTINGS];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   remote_command_byte_parser dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_direction      (rsp_direction),
      .rsp_speed          (rsp_speed),
      .rsp_kp_gain        (rsp_kp_gain),
      .rsp_ki_gain        (rsp_ki_gain),
      .rsp_kp_written     (rsp_kp_written),
      .rsp_ki_written     (rsp_ki_written),
      .rsp_report_request (rsp_report_request),
      .rsp_save_request   (rsp_save_request),
      .rsp_echo_byte      (rsp_echo_byte),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   rcbp_result_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_direction      (rsp_direction),
      .rsp_speed          (rsp_speed),
      .rsp_kp_gain        (rsp_kp_gain),
      .rsp_ki_gain        (rsp_ki_gain),
      .rsp_kp_written     (rsp_kp_written),
      .rsp_ki_written     (rsp_ki_written),
      .rsp_report_request (rsp_report_request),
      .rsp_save_request   (rsp_save_request),
      .rsp_echo_byte      (rsp_echo_byte),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .test_done          (test_done),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .checked_count      (checked_count),
      .gain_loads         (gain_loads),
      .request_count      (request_count)
   );

   // receiver back-pressure, re-rolled every cycle at the falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   // one byte transfer: optional idle gap, then hold until the parser takes it
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // stop sending and wait for every outstanding result (the timeout bounds this)
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [7:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // lone command bytes, weighted towards the ones that do something
   task automatic send_command();
      int pick;
      pick = $urandom_range(99);
      if (pick < 25) send_byte(BYTE_DIR_LO + 8'($urandom_range(7)));
      else if (pick < 40) send_byte(8'($urandom_range(9)));
      else if (pick < 50) send_byte(BYTE_STOP);
      else if (pick < 62) send_byte(BYTE_SPEED_UP);
      else if (pick < 74) send_byte(BYTE_SPEED_DOWN);
      else if (pick < 80) send_byte(BYTE_CLOSE);
      else send_byte(8'($urandom_range(255)));
   endtask

   // one frame with random content; some are left open, some run past the frame limit
   task automatic send_frame();
      int         shape;
      int         id_pick;
      int         n_digits;
      logic [7:0] id;
      logic [7:0] b;
      shape   = $urandom_range(99);
      id_pick = $urandom_range(99);
      if (id_pick < 30) id = BYTE_ID_KP;
      else if (id_pick < 60) id = BYTE_ID_KI;
      else if (id_pick < 70) id = BYTE_ID_NONE;
      else id = 8'($urandom_range(255));
      if (id == BYTE_CLOSE) id = BYTE_ID_KP;

      send_byte(BYTE_OPEN);
      send_byte(id);
      if (shape < 8) begin
         // short frame, closes before byte three
         send_byte(BYTE_CLOSE);
      end else begin
         b = 8'($urandom_range(255));
         send_byte(b == BYTE_CLOSE ? BYTE_ZERO_CHAR : b);
         if (shape < 18) send_byte(BYTE_REPORT);
         else if (shape < 28) send_byte(BYTE_SAVE);
         if ($urandom_range(29) == 0) n_digits = $urandom_range(60, 75);
         else if ($urandom_range(5) == 0) n_digits = $urandom_range(10, 16);
         else n_digits = $urandom_range(0, 9);
         for (int i = 0; i < n_digits; i++) begin
            if (shape >= 94) b = 8'($urandom_range(47));          // drives towards negative saturation
            else if ($urandom_range(9) != 0) b = BYTE_ZERO_CHAR + 8'($urandom_range(9));
            else b = 8'($urandom_range(255));
            send_byte(b == BYTE_CLOSE ? BYTE_ZERO_CHAR : b);
         end
         // a few frames are never closed so the next one lands inside them
         if ($urandom_range(11) != 0) send_byte(BYTE_CLOSE);
      end
   endtask

   initial begin
      step_setting = '{SPEED_STEP_RESET, 8'd255, 8'd0, 8'd1,
                       8'($urandom_range(255)), 8'($urandom_range(1, 40))};
      max_setting  = '{SPEED_MAX_RESET, 8'd255, 8'd0, 8'd255,
                       8'($urandom_range(255)), 8'($urandom_range(100, 254))};

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      tx_idle_pct = 35;
      rx_idle_pct = 51;

      // directed: field extremes, every command kind, frame corner cases
      send_byte(8'h00);
      send_byte(8'h09);
      send_byte(BYTE_DIR_LO);
      send_byte(BYTE_DIR_HI);
      send_byte(BYTE_DIGIT_LIM);        // just above the raw direction range
      send_byte(BYTE_STOP);
      send_byte(BYTE_SPEED_UP);
      send_byte(BYTE_SPEED_DOWN);
      send_byte(BYTE_SPEED_DOWN);       // clamps at zero
      send_byte(8'hFF);
      send_byte(BYTE_CLOSE);            // stray close outside a frame
      // short frame loads zero into kp
      send_byte(BYTE_OPEN);
      send_byte(BYTE_ID_KP);
      send_byte(BYTE_CLOSE);
      // save request on a ki frame
      send_byte(BYTE_OPEN);
      send_byte(BYTE_ID_KI);
      send_byte(8'h78);
      send_byte(BYTE_SAVE);
      send_byte(BYTE_CLOSE);
      // nested open brace counted as an ordinary frame byte, then a report request
      send_byte(BYTE_OPEN);
      send_byte(BYTE_ID_NONE);
      send_byte(BYTE_OPEN);
      send_byte(BYTE_REPORT);
      send_byte(BYTE_CLOSE);

      // random traffic under each register setting and idling pattern
      for (int s = 0; s < NUM_SETTINGS; s++) begin
         if (s != 0) begin
            hold_until_drained();
            write_register(CSR_SPEED_STEP, step_setting[s]);
            write_register(CSR_SPEED_MAX, max_setting[s]);
         end
         if (s < 2) begin
            tx_idle_pct = 35;
            rx_idle_pct = 51;
         end else if (s < 4) begin
            tx_idle_pct = 51;
            rx_idle_pct = 35;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         while (bytes_sent < 24 + (s + 1) * BYTES_PER_SETTING) begin
            if ($urandom_range(99) < 55) send_frame();
            else send_command();
         end
      end

      hold_until_drained();
      repeat (10) @(posedge clock);
      @(negedge clock);
      test_done <= 1'b1;
      @(posedge clock);
      @(negedge clock);

      $display("%0d bytes sent under %0d register settings, %0d results compared",
               bytes_sent, NUM_SETTINGS, checked_count);
      $display("%0d gain loads and %0d report or save requests seen",
               gain_loads, request_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // hard stop in case a handshake never completes
   initial begin
      #(3_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule
